### hw/rtl/brle_pkg.sv
// shared types, codes and defaults for the byte run-length decoder
package brle_pkg;

  localparam int DEF_BYTES_PER_WORD = 8;
  localparam int DEF_COUNT_BITS     = 16;

  // physical lanes in the 64-bit output word
  localparam int WORD_LANES = 8;
  localparam int CAP_BITS   = 16;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_ZERO     = 2'd1,
    STAT_TRUNC    = 2'd2,
    STAT_OVERFLOW = 2'd3
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic take_byte;
    logic take_rep;
    logic emit_rep;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic phase_rep;
    logic rep_last;
    logic out_free;
  } stat_t;

endpackage

### hw/rtl/brle_in_if.sv
// compressed byte channel
interface brle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       stream_end;

  modport source (output valid, output code_byte, output stream_end, input ready);
  modport sink (input valid, input code_byte, input stream_end, output ready);
endinterface

### hw/rtl/brle_out_if.sv
// decoded word channel
interface brle_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_word;
  logic [3:0]  byte_count;
  logic        item_done;
  logic        stream_done;
  logic [1:0]  status;
  logic [15:0] total_bytes;

  modport source (
    output valid, output data_word, output byte_count, output item_done,
    output stream_done, output status, output total_bytes, input ready
  );
  modport sink (
    input valid, input data_word, input byte_count, input item_done,
    input stream_done, input status, input total_bytes, output ready
  );
endinterface

### hw/rtl/brle_ctrl.sv
// sequencing controller: takes bytes and walks repeat runs out word by word
module brle_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  brle_pkg::stat_t  stat,
  output logic             in_ready,
  output brle_pkg::cmd_t   cmd
);
  import brle_pkg::*;

  typedef enum logic {S_IN, S_REP} state_t;

  state_t state;
  logic   take;

  always_comb begin
    in_ready      = (state == S_IN) && stat.out_free;
    take          = in_ready && in_valid;
    cmd.take_byte = take && !stat.phase_rep;
    cmd.take_rep  = take && stat.phase_rep;
    cmd.emit_rep  = (state == S_REP) && stat.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IN;
    end else begin
      unique case (state)
        S_IN: begin
          if (cmd.take_rep) state <= S_REP;
        end
        S_REP: begin
          if (cmd.emit_rep && stat.rep_last) state <= S_IN;
        end
        default: state <= S_IN;
      endcase
    end
  end

  a_rep_enter: assert property (@(posedge clk) disable iff (rst)
    cmd.take_rep |=> state == S_REP) else $error("repeat run not entered");
  a_rep_stall: assert property (@(posedge clk) disable iff (rst)
    state == S_REP |-> !in_ready) else $error("input taken during repeat run");
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    !(take && cmd.emit_rep)) else $error("byte taken while a repeat word is emitted");

endmodule

### hw/rtl/brle_dp.sv
// decoder datapath: stream state, capacity check, word packing, output register
module brle_dp #(
  parameter int BYTES_PER_WORD = brle_pkg::DEF_BYTES_PER_WORD,
  parameter int COUNT_BITS     = brle_pkg::DEF_COUNT_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  brle_pkg::cmd_t                cmd,
  output brle_pkg::stat_t               stat,
  input  logic [7:0]                    code_byte,
  input  logic                          stream_end,
  input  logic                          cfg_we,
  input  logic [brle_pkg::CAP_BITS-1:0] cfg_wdata,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [63:0]                   out_data_word,
  output logic [3:0]                    out_byte_count,
  output logic                          out_item_done,
  output logic                          out_stream_done,
  output logic [1:0]                    out_status,
  output logic [15:0]                   out_total
);
  import brle_pkg::*;

  localparam int SUM_W = ((COUNT_BITS > CAP_BITS) ? COUNT_BITS : CAP_BITS) + 1;
  localparam logic [6:0] TAKE_MAX = 7'(BYTES_PER_WORD);

  typedef enum logic [1:0] {PH_CTRL, PH_LIT, PH_REP, PH_ERR} phase_t;

  // stream state
  phase_t                phase, phase_next;
  logic [6:0]            remaining, remaining_next;
  logic [COUNT_BITS-1:0] decoded_count, decoded_count_next;
  status_t               error_code, error_code_next;
  logic [CAP_BITS-1:0]   capacity;

  // repeat run under emission
  logic [7:0] rep_byte;
  logic [6:0] rep_left, rep_left_next;
  logic       rep_end;

  // next output word
  logic        load_out;
  logic [63:0] data_word_next;
  logic [3:0]  byte_count_next;
  logic        item_done_next;
  logic        stream_done_next;
  status_t     status_next;
  logic [15:0] total_next;

  status_t    err, err_now;
  logic [6:0] cnt, take, rem_dec;
  logic [SUM_W-1:0] run_sum;

  assign stat.out_free  = !out_valid || out_ready;
  assign stat.phase_rep = (phase == PH_REP);
  assign stat.rep_last  = (rep_left <= TAKE_MAX);

  always_comb begin
    phase_next         = phase;
    remaining_next     = remaining;
    decoded_count_next = decoded_count;
    error_code_next    = error_code;
    rep_left_next      = rep_left;
    load_out           = 1'b0;
    data_word_next     = '0;
    byte_count_next    = '0;
    item_done_next     = 1'b0;
    stream_done_next   = 1'b0;
    status_next        = STAT_OK;
    total_next         = '0;
    err                = STAT_OK;
    err_now            = STAT_OK;
    cnt                = code_byte[6:0];
    take               = (rep_left < TAKE_MAX) ? rep_left : TAKE_MAX;
    rem_dec            = remaining - 7'd1;
    run_sum            = SUM_W'(decoded_count) + SUM_W'(cnt);

    if (cmd.take_byte) begin
      unique case (phase)
        PH_CTRL: begin
          // zero count first, then truncation, then capacity
          if (cnt == 7'd0) begin
            err = STAT_ZERO;
          end else if (stream_end) begin
            err = STAT_TRUNC;
          end else if (run_sum > SUM_W'(capacity)) begin
            err = STAT_OVERFLOW;
          end else begin
            remaining_next = cnt;
            phase_next     = code_byte[7] ? PH_LIT : PH_REP;
          end
        end
        PH_LIT: begin
          load_out           = 1'b1;
          data_word_next     = 64'(code_byte);
          byte_count_next    = 4'd1;
          decoded_count_next = decoded_count + COUNT_BITS'(1);
          remaining_next     = rem_dec;
          if (rem_dec == 7'd0) begin
            phase_next = PH_CTRL;
          end else if (stream_end) begin
            err = STAT_TRUNC;
          end
        end
        PH_REP: begin
        end
        PH_ERR: begin
        end
        default: begin
        end
      endcase

      if (err != STAT_OK) begin
        error_code_next = err;
        phase_next      = PH_ERR;
        remaining_next  = '0;
      end
      err_now = (err != STAT_OK) ? err : error_code;

      if (stream_end) begin
        load_out           = 1'b1;
        stream_done_next   = 1'b1;
        status_next        = err_now;
        total_next         = (err_now == STAT_OK) ? 16'(decoded_count_next) : '0;
        phase_next         = PH_CTRL;
        remaining_next     = '0;
        decoded_count_next = '0;
        error_code_next    = STAT_OK;
      end
      item_done_next = load_out;
    end

    if (cmd.take_rep) begin
      decoded_count_next = decoded_count + COUNT_BITS'(remaining);
      remaining_next     = '0;
      phase_next         = PH_CTRL;
      rep_left_next      = remaining;
    end

    if (cmd.emit_rep) begin
      load_out        = 1'b1;
      byte_count_next = 4'(take);
      rep_left_next   = rep_left - take;
      for (int k = 0; k < WORD_LANES; k++) begin
        if (k < BYTES_PER_WORD && 7'(k) < take) data_word_next[8*k +: 8] = rep_byte;
      end
      if (stat.rep_last) begin
        item_done_next = 1'b1;
        if (rep_end) begin
          // count was settled when the run was taken
          stream_done_next   = 1'b1;
          total_next         = 16'(decoded_count);
          phase_next         = PH_CTRL;
          remaining_next     = '0;
          decoded_count_next = '0;
          error_code_next    = STAT_OK;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_CTRL;
      remaining     <= '0;
      decoded_count <= '0;
      error_code    <= STAT_OK;
      capacity      <= '1;
      out_valid     <= 1'b0;
    end else begin
      phase         <= phase_next;
      remaining     <= remaining_next;
      decoded_count <= decoded_count_next;
      error_code    <= error_code_next;
      if (cfg_we) capacity <= cfg_wdata;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rep_left <= rep_left_next;
    if (cmd.take_rep) begin
      rep_byte <= code_byte;
      rep_end  <= stream_end;
    end
    if (load_out) begin
      out_data_word   <= data_word_next;
      out_byte_count  <= byte_count_next;
      out_item_done   <= item_done_next;
      out_stream_done <= stream_done_next;
      out_status      <= status_next;
      out_total       <= total_next;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_byte_count <= 4'(BYTES_PER_WORD))
    else $error("word carries more bytes than a word holds");
  a_status_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stream_done |-> out_status == STAT_OK && out_total == '0)
    else $error("status or total on a word that does not end the stream");
  a_end_item: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stream_done |-> out_item_done)
    else $error("stream end word not marked as last of its byte");
  a_err_phase: assert property (@(posedge clk) disable iff (rst)
    phase == PH_ERR |-> remaining == '0 && error_code != STAT_OK)
    else $error("error phase without a recorded error");

endmodule

### hw/rtl/byte_rle_decoder.sv
// top level of the byte run-length decoder
//
//   channel  dir  payload                                           handshake
//   code     in   code_byte, stream_end                             valid/ready
//   words    out  data_word, byte_count, item_done, stream_done,    valid/ready
//                 status, total_bytes
//   cfg      in   cfg_wdata (out_capacity)                          cfg_we
//
// control and literal bytes go straight in; a repeat run leaves in words of up to
// BYTES_PER_WORD bytes, one word per cycle while the output is free, input held off
// a word leaves through one output register; a stalled word only blocks new input
// when the register is still full at the next edge
// rst is synchronous and clears stream state; out_capacity returns to 65535
module byte_rle_decoder #(
  parameter int BYTES_PER_WORD = brle_pkg::DEF_BYTES_PER_WORD,
  parameter int COUNT_BITS     = brle_pkg::DEF_COUNT_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  brle_in_if.sink                       code,
  brle_out_if.source                    words,
  input  logic                          cfg_we,
  input  logic [brle_pkg::CAP_BITS-1:0] cfg_wdata
);
  import brle_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  in_ready;

  assign code.ready = in_ready;

  brle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (code.valid),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  brle_dp #(
    .BYTES_PER_WORD (BYTES_PER_WORD),
    .COUNT_BITS     (COUNT_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .code_byte       (code.code_byte),
    .stream_end      (code.stream_end),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .out_ready       (words.ready),
    .out_valid       (words.valid),
    .out_data_word   (words.data_word),
    .out_byte_count  (words.byte_count),
    .out_item_done   (words.item_done),
    .out_stream_done (words.stream_done),
    .out_status      (words.status),
    .out_total       (words.total_bytes)
  );

endmodule
